[rtl/mppq_pkg.sv]
// shared constants, command codes and types of the multilevel priority packet queue
package mppq_pkg;

	localparam int LEVELS       = 4;
	localparam int DEPTH        = 8;
	localparam int PACKET_BYTES = 4;

	localparam int CMD_W    = 3;
	localparam int LEVEL_W  = 3;
	localparam int PACKET_W = 32;

	// stored width: the port carries at most 32 bits of the packet
	localparam int PKT_W  = (PACKET_BYTES * 8 > PACKET_W) ? PACKET_W : PACKET_BYTES * 8;
	localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SLOTS  = LEVELS * DEPTH;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int CMDQ_DEPTH = 2;
	localparam int QPTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int QCNT_W     = $clog2(CMDQ_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_ENQ        = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_DEQ        = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_PEEK       = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_PEEK_FIRST = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_FLUSH      = CMD_W'(4);

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ENQ,
		OP_DEQ,
		OP_PEEK,
		OP_PEEK_FIRST,
		OP_FLUSH
	} op_kind_t;

	typedef struct packed {
		op_kind_t           kind;
		logic               lvl_ok;
		logic [LEVEL_W-1:0] level;
		logic [PKT_W-1:0]   packet;
	} op_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [PKT_W-1:0]  wdata;
	} ram_req_t;

endpackage

[rtl/mppq_req_if.sv]
// request channel: command, level and packet words
interface mppq_req_if import mppq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [LEVEL_W-1:0]  level;
	logic [PACKET_W-1:0] packet;

	modport source (output valid, output cmd, output level, output packet, input ready);
	modport sink   (input valid, input cmd, input level, input packet, output ready);
endinterface

[rtl/mppq_rsp_if.sv]
// response channel: status and packet words
interface mppq_rsp_if import mppq_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                ok;
	logic [PACKET_W-1:0] packet_out;
	logic                level_full;
	logic                level_empty;
	logic                all_full;
	logic                all_empty;

	modport source (output valid, output ok, output packet_out, output level_full,
		output level_empty, output all_full, output all_empty, input ready);
	modport sink   (input valid, input ok, input packet_out, input level_full,
		input level_empty, input all_full, input all_empty, output ready);
endinterface

[rtl/multilevel_priority_packet_queue.sv]
// top level of the multilevel priority packet queue
// Usage:
// req carries one command word per valid/ready handshake: cmd (enqueue,
// dequeue, peek level, peek most urgent, flush), level and packet. rsp
// returns exactly one word per request, in order: ok, packet_out, status
// of the named level and of the whole queue after the command.
// A request is classified by the front end and placed in a two-entry
// operation queue; the back end takes one operation at a time: ST_IDLE
// does the level search, pointer update and the packet ram access, and
// ST_FINISH loads the response register, waiting while it is not free.
// No new operation is taken until the response register is loaded.
// A request passes the operation queue, the ST_IDLE and ST_FINISH states
// of the back end and the response register on its way to rsp.valid.
// Reset empties every level at once (pointers and counts clear); the ram
// is not cleared and no start-up pass is needed.
// When rsp stalls, one finished response waits in the output register,
// one more waits in the back end, and the operation queue keeps taking
// requests until it fills; then req.ready drops.
module multilevel_priority_packet_queue import mppq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mppq_req_if.sink   req,
	mppq_rsp_if.source rsp
);

	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	op_t              push_op;
	op_t              pop_op;
	ram_req_t         ram_req;
	logic [PKT_W-1:0] ram_rdata;

	mppq_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (push_op)
	);

	mppq_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (q_pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	mppq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_op      (pop_op),
		.q_pop     (q_pop),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.rsp       (rsp)
	);

	mppq_ram #(
		.WIDTH (PKT_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.en    (ram_req.en),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

endmodule

[rtl/mppq_ram.sv]
// generic single-port ram with registered read
module mppq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[rtl/mppq_front.sv]
// front end: takes request words and classifies them into queue operations
module mppq_front import mppq_pkg::*; (
	mppq_req_if.sink req,
	input  logic     q_full,
	output logic     q_push,
	output op_t      q_op
);

	logic lvl_ok;

	assign lvl_ok    = {1'b0, req.level} < (LEVEL_W + 1)'(LEVELS);
	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;

	always_comb begin
		q_op.lvl_ok = lvl_ok;
		q_op.level  = req.level;
		q_op.packet = req.packet[PKT_W-1:0];
		case (req.cmd)
			CMD_ENQ:        q_op.kind = lvl_ok ? OP_ENQ : OP_NOP;
			CMD_DEQ:        q_op.kind = lvl_ok ? OP_DEQ : OP_NOP;
			CMD_PEEK:       q_op.kind = lvl_ok ? OP_PEEK : OP_NOP;
			CMD_PEEK_FIRST: q_op.kind = OP_PEEK_FIRST;
			CMD_FLUSH:      q_op.kind = OP_FLUSH;
			default:        q_op.kind = OP_NOP;
		endcase
	end

endmodule

[rtl/mppq_cmdq.sv]
// short operation queue between front end and back end
module mppq_cmdq import mppq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  pop_op,
	output logic empty
);

	op_t               ent_q [CMDQ_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = cnt_q == QCNT_W'(CMDQ_DEPTH);
	assign empty  = cnt_q == '0;
	assign pop_op = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

endmodule

[rtl/mppq_back.sv]
// back end: level search, pointer and count update, ram access, response register
module mppq_back import mppq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  op_t        q_op,
	output logic       q_pop,
	output ram_req_t   ram_req,
	input  logic [PKT_W-1:0] ram_rdata,
	mppq_rsp_if.source rsp
);

	typedef enum logic {
		ST_IDLE,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  head_q [LEVELS];
	logic [PTR_W-1:0]  tail_q [LEVELS];
	logic [CNT_W-1:0]  cnt_q  [LEVELS];

	logic              ok_q;
	logic              rd_q;
	logic              lvl_ok_q;
	logic [LIDX_W-1:0] lidx_q;

	logic                valid_q;
	logic                ok_out_q;
	logic [PACKET_W-1:0] pkt_out_q;
	logic                lf_out_q;
	logic                le_out_q;
	logic                af_out_q;
	logic                ae_out_q;

	logic              issue;
	logic              found;
	logic [LIDX_W-1:0] sel;
	logic [LIDX_W-1:0] lsel;
	logic [PTR_W-1:0]  slot;
	logic              lvl_full;
	logic              lvl_empty;
	logic              all_full;
	logic              all_empty;
	logic              out_free;

	assign lsel     = q_op.level[LIDX_W-1:0];
	assign issue    = (state_q == ST_IDLE) && !q_empty;
	assign q_pop    = issue;
	assign out_free = !valid_q || rsp.ready;

	// first level that can serve the operation
	always_comb begin
		logic hit;
		logic l_full;
		logic l_empty;
		found = 1'b0;
		sel   = '0;
		for (int l = 0; l < LEVELS; l++) begin
			l_full  = cnt_q[l] == CNT_W'(DEPTH);
			l_empty = cnt_q[l] == '0;
			case (q_op.kind)
				OP_ENQ:        hit = (l >= int'(lsel)) && !l_full;
				OP_DEQ:        hit = (l >= int'(lsel)) && !l_empty;
				OP_PEEK:       hit = (l == int'(lsel)) && !l_empty;
				OP_PEEK_FIRST: hit = !l_empty;
				default:       hit = 1'b0;
			endcase
			if (hit && !found) begin
				found = 1'b1;
				sel   = LIDX_W'(l);
			end
		end
	end

	assign slot          = (q_op.kind == OP_ENQ) ? tail_q[sel] : head_q[sel];
	assign ram_req.en    = issue && found;
	assign ram_req.we    = q_op.kind == OP_ENQ;
	assign ram_req.addr  = ADDR_W'(ADDR_W'(sel) * ADDR_W'(DEPTH) + ADDR_W'(slot));
	assign ram_req.wdata = q_op.packet;

	// status after the update, taken from the counts
	always_comb begin
		all_full  = 1'b1;
		all_empty = 1'b1;
		for (int l = 0; l < LEVELS; l++) begin
			if (cnt_q[l] != CNT_W'(DEPTH)) all_full = 1'b0;
			if (cnt_q[l] != '0) all_empty = 1'b0;
		end
		lvl_full  = !lvl_ok_q || (cnt_q[lidx_q] == CNT_W'(DEPTH));
		lvl_empty = lvl_ok_q && (cnt_q[lidx_q] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ok_q      <= 1'b0;
			rd_q      <= 1'b0;
			lvl_ok_q  <= 1'b0;
			lidx_q    <= '0;
			valid_q   <= 1'b0;
			ok_out_q  <= 1'b0;
			pkt_out_q <= '0;
			lf_out_q  <= 1'b0;
			le_out_q  <= 1'b0;
			af_out_q  <= 1'b0;
			ae_out_q  <= 1'b0;
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l]  <= '0;
			end
		end else begin
			// in ST_FINISH a free output register is reloaded instead
			if (rsp.ready && state_q != ST_FINISH) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (issue) begin
						ok_q     <= found;
						rd_q     <= found && (q_op.kind != OP_ENQ);
						lvl_ok_q <= q_op.lvl_ok;
						lidx_q   <= lsel;
						if (q_op.kind == OP_FLUSH) begin
							for (int l = 0; l < LEVELS; l++) begin
								head_q[l] <= '0;
								tail_q[l] <= '0;
								cnt_q[l]  <= '0;
							end
						end else if (found && q_op.kind == OP_ENQ) begin
							tail_q[sel] <= (tail_q[sel] == PTR_W'(DEPTH - 1)) ? '0
								: tail_q[sel] + 1'b1;
							cnt_q[sel]  <= cnt_q[sel] + 1'b1;
						end else if (found && q_op.kind == OP_DEQ) begin
							head_q[sel] <= (head_q[sel] == PTR_W'(DEPTH - 1)) ? '0
								: head_q[sel] + 1'b1;
							cnt_q[sel]  <= cnt_q[sel] - 1'b1;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// ram read data holds until the response register frees up
					if (out_free) begin
						valid_q   <= 1'b1;
						ok_out_q  <= ok_q;
						pkt_out_q <= rd_q ? PACKET_W'(ram_rdata) : '0;
						lf_out_q  <= lvl_full;
						le_out_q  <= lvl_empty;
						af_out_q  <= all_full;
						ae_out_q  <= all_empty;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.ok          = ok_out_q;
	assign rsp.packet_out  = pkt_out_q;
	assign rsp.level_full  = lf_out_q;
	assign rsp.level_empty = le_out_q;
	assign rsp.all_full    = af_out_q;
	assign rsp.all_empty   = ae_out_q;

endmodule

[rtl/mppq_chk.sv]
// port-level checker for the multilevel priority packet queue, bound to the top level
module mppq_chk import mppq_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic                ok,
	input logic [PACKET_W-1:0] packet_out,
	input logic                level_full,
	input logic                level_empty,
	input logic                all_full,
	input logic                all_empty
);

	// a failed command never returns packet data
	a_no_data_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> packet_out == '0)
		else $error("packet_out nonzero with ok low");

	// a level cannot be full and empty at once
	a_level_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(level_full && level_empty))
		else $error("level_full and level_empty both set");

	// the whole queue cannot be full and empty at once
	a_all_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(all_full && all_empty))
		else $error("all_full and all_empty both set");

	// a stalled response word holds ok, packet_out and the whole-queue status
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(packet_out)
			&& $stable(all_full) && $stable(all_empty))
		else $error("stalled response changed");

endmodule

bind multilevel_priority_packet_queue mppq_chk u_mppq_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.ok          (rsp.ok),
	.packet_out  (rsp.packet_out),
	.level_full  (rsp.level_full),
	.level_empty (rsp.level_empty),
	.all_full    (rsp.all_full),
	.all_empty   (rsp.all_empty)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench of the multilevel priority packet queue
module tb;
	import mppq_pkg::*;

	localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_FLUSH + 1'b1;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = {CMD_W{1'b1}};
	localparam int RANDOM_WORDS  = 1600;
	localparam int BURST_WORDS   = 96;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_FROM    = 1500;
	localparam int QUIET_TO      = 2500;
	localparam int IDLE_PCT      = 7;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		bit                  drain;
		logic [CMD_W-1:0]    cmd;
		logic [LEVEL_W-1:0]  level;
		logic [PACKET_W-1:0] packet;
	} req_word_t;

	typedef struct packed {
		logic                ok;
		logic [PACKET_W-1:0] packet_out;
		logic                level_full;
		logic                level_empty;
		logic                all_full;
		logic                all_empty;
	} rsp_word_t;

	logic clk;
	logic arst_n;

	mppq_req_if req();
	mppq_rsp_if rsp();

	multilevel_priority_packet_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the queue contents
	logic [PKT_W-1:0] held [LEVELS][DEPTH];
	logic [PTR_W-1:0] rd_slot [LEVELS];
	logic [PTR_W-1:0] wr_slot [LEVELS];
	logic [CNT_W-1:0] fill [LEVELS];

	req_word_t pending [$];
	rsp_word_t status_due [$];
	req_word_t presented;

	int cyc = 0;
	int errors = 0;
	int words_taken = 0;
	int words_checked = 0;
	int rejected_enq = 0;
	int full_seen = 0;
	int empty_takes = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("[multilevel_priority_packet_queue] ERROR");
			$finish;
		end
	end

	function automatic bit idle_roll();
		if (cyc >= QUIET_FROM && cyc < QUIET_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	function automatic logic no_room(int l);
		if (l >= LEVELS)
			return 1'b1;
		return fill[l] == DEPTH;
	endfunction

	function automatic logic vacant(int l);
		if (l >= LEVELS)
			return 1'b0;
		return fill[l] == 0;
	endfunction

	function automatic logic [PTR_W-1:0] step_ptr(logic [PTR_W-1:0] p);
		return (p == DEPTH - 1) ? '0 : p + 1'b1;
	endfunction

	// applies one request word to the shadow queue and returns its status word
	function automatic rsp_word_t queue_apply(req_word_t w);
		rsp_word_t r;
		logic [PKT_W-1:0] taken;
		int l;
		r = '0;
		taken = '0;
		case (w.cmd)
		CMD_ENQ: begin
			if (w.level < LEVELS) begin
				for (l = int'(w.level); l < LEVELS && !r.ok; l++) begin
					if (!no_room(l)) begin
						held[l][wr_slot[l]] = w.packet[PKT_W-1:0];
						wr_slot[l] = step_ptr(wr_slot[l]);
						fill[l] = fill[l] + 1'b1;
						r.ok = 1'b1;
					end
				end
				if (!r.ok)
					rejected_enq++;
			end
		end
		CMD_DEQ: begin
			if (w.level < LEVELS) begin
				for (l = int'(w.level); l < LEVELS && !r.ok; l++) begin
					if (!vacant(l)) begin
						taken = held[l][rd_slot[l]];
						rd_slot[l] = step_ptr(rd_slot[l]);
						fill[l] = fill[l] - 1'b1;
						r.ok = 1'b1;
					end
				end
				if (!r.ok)
					empty_takes++;
			end
		end
		CMD_PEEK: begin
			if (w.level < LEVELS && !vacant(int'(w.level))) begin
				taken = held[w.level][rd_slot[w.level]];
				r.ok = 1'b1;
			end
		end
		CMD_PEEK_FIRST: begin
			// search ignores the level input
			for (l = 0; l < LEVELS && !r.ok; l++) begin
				if (!vacant(l)) begin
					taken = held[l][rd_slot[l]];
					r.ok = 1'b1;
				end
			end
		end
		CMD_FLUSH: begin
			for (l = 0; l < LEVELS; l++) begin
				rd_slot[l] = '0;
				wr_slot[l] = '0;
				fill[l] = '0;
			end
		end
		default: begin
		end
		endcase
		r.packet_out = r.ok ? PACKET_W'(taken) : '0;
		r.level_full = no_room(int'(w.level));
		r.level_empty = vacant(int'(w.level));
		r.all_full = 1'b1;
		r.all_empty = 1'b1;
		for (l = 0; l < LEVELS; l++) begin
			r.all_full &= no_room(l);
			r.all_empty &= vacant(l);
		end
		if (r.all_full)
			full_seen++;
		return r;
	endfunction

	task automatic add_word(logic [CMD_W-1:0] c, logic [LEVEL_W-1:0] lv,
		logic [PACKET_W-1:0] p);
		req_word_t w;
		w.drain = 1'b0;
		w.cmd = c;
		w.level = lv;
		w.packet = p;
		pending.push_back(w);
	endtask

	task automatic add_drain();
		req_word_t w;
		w = '{drain: 1'b1, cmd: CMD_ENQ, level: '0, packet: '0};
		pending.push_back(w);
	endtask

	// driver: presents pending words, holds them until taken
	always @(posedge clk or negedge arst_n) begin : drive_req
		rsp_word_t predicted;
		bit send;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.cmd <= CMD_ENQ;
			req.level <= '0;
			req.packet <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				rd_slot[i] = '0;
				wr_slot[i] = '0;
				fill[i] = '0;
			end
		end else begin
			if (req.valid && req.ready) begin
				predicted = queue_apply(presented);
				status_due.push_back(predicted);
				words_taken++;
			end
			if (!req.valid || req.ready) begin
				// hold-off point: wait for every outstanding response
				if (pending.size() > 0 && pending[0].drain && status_due.size() == 0)
					void'(pending.pop_front());
				send = pending.size() > 0 && !pending[0].drain && !idle_roll();
				if (send) begin
					presented = pending.pop_front();
					req.cmd <= presented.cmd;
					req.level <= presented.level;
					req.packet <= presented.packet;
				end
				req.valid <= send;
			end
		end
	end

	// monitor: checks each response against the oldest predicted status
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		rsp_word_t want;
		rsp_word_t got;
		bit bad;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.ok = rsp.ok;
				got.packet_out = rsp.packet_out;
				got.level_full = rsp.level_full;
				got.level_empty = rsp.level_empty;
				got.all_full = rsp.all_full;
				got.all_empty = rsp.all_empty;
				if (status_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("unexpected response ok=%0b pkt=%h", got.ok, got.packet_out);
				end else begin
					want = status_due.pop_front();
					bad = (got.ok !== want.ok) || (got.packet_out !== want.packet_out) ||
						(got.level_full !== want.level_full) ||
						(got.level_empty !== want.level_empty) ||
						(got.all_full !== want.all_full) ||
						(got.all_empty !== want.all_empty);
					if (bad) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display("mismatch at response %0d: expected ok=%0b pkt=%h lf=%0b le=%0b af=%0b ae=%0b",
								words_checked, want.ok, want.packet_out, want.level_full,
								want.level_empty, want.all_full, want.all_empty);
							$display("    got ok=%0b pkt=%h lf=%0b le=%0b af=%0b ae=%0b",
								got.ok, got.packet_out, got.level_full,
								got.level_empty, got.all_full, got.all_empty);
						end
					end
				end
				words_checked++;
			end
			rsp.ready <= !idle_roll();
		end
	end

	initial begin : stimulus
		int n;
		int i;
		int mode;
		int roll;
		logic [CMD_W-1:0] c;
		logic [LEVEL_W-1:0] lv;
		clk = 1'b0;
		arst_n = 1'b0;

		// directed corner cases
		add_word(CMD_PEEK_FIRST, 0, 32'h1234_5678);
		add_word(CMD_DEQ, 0, '0);
		add_word(CMD_PEEK, LEVEL_W'(LEVELS - 1), '0);
		add_word(CMD_ENQ, 0, '0);
		add_word(CMD_ENQ, 0, '1);
		add_word(CMD_ENQ, LEVEL_W'(LEVELS), 32'hdead_beef);
		add_word(CMD_ENQ, LEVEL_W'(LEVEL_MAX), 32'hfeed_f00d);
		add_word(CMD_DEQ, LEVEL_W'(LEVEL_MAX), '0);
		add_word(CMD_PEEK, LEVEL_W'(LEVELS + 1), '0);
		add_word(CMD_PEEK_FIRST, LEVEL_W'(LEVEL_MAX - 1), '0);
		add_word(CMD_PEEK, 2, '0);
		add_word(CMD_PEEK, 0, '0);
		add_word(CMD_DEQ, 1, '0);
		// fill the least urgent level, then one more is turned away
		for (i = 0; i <= DEPTH; i++)
			add_word(CMD_ENQ, LEVEL_W'(LEVELS - 1), {8'ha5, 8'(i), 16'h5a5a});
		add_word(CMD_DEQ, 1, '0);
		add_word(CMD_DEQ, 0, '0);
		add_word(CMD_SPARE_LO, 1, '1);
		add_word(CMD_SPARE_HI, LEVEL_W'(LEVELS - 1), '0);
		add_word(CMD_FLUSH, 2, '0);
		add_word(CMD_PEEK_FIRST, 0, '0);
		add_drain();

		// random bursts: fill-heavy, drain-heavy or mixed
		mode = 0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % BURST_WORDS == 0)
				mode = $urandom_range(0, 2);
			if (n == RANDOM_WORDS / 2)
				add_drain();
			roll = $urandom_range(0, 99);
			if (roll < 2)
				c = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			else if (roll < 4 && mode == 2)
				c = CMD_FLUSH;
			else if (roll < 10)
				c = CMD_PEEK;
			else if (roll < 16)
				c = CMD_PEEK_FIRST;
			else if (mode == 0)
				c = (roll < 85) ? CMD_ENQ : CMD_DEQ;
			else if (mode == 1)
				c = (roll < 35) ? CMD_ENQ : CMD_DEQ;
			else
				c = (roll < 58) ? CMD_ENQ : CMD_DEQ;
			if ($urandom_range(0, 99) < 7)
				lv = LEVEL_W'($urandom_range(LEVELS, LEVEL_MAX));
			else
				lv = LEVEL_W'($urandom_range(0, LEVELS - 1));
			add_word(c, lv, $urandom());
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() > 0 || req.valid || status_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d request words and %0d checked responses",
			words_taken, words_checked);
		$display("%0d enqueues turned away, %0d dequeues found nothing, %0d times full",
			rejected_enq, empty_takes, full_seen);
		if (errors == 0 && status_due.size() == 0)
			$display("[multilevel_priority_packet_queue] OK");
		else
			$display("[multilevel_priority_packet_queue] ERROR");
		$finish;
	end

endmodule
